/* design/binned_score_histogram_top_assert.svh */
// ----------------------------------------------------------------------------
// Binned score histogram assertion macros
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINNED_SCORE_HISTOGRAM_TOP_ASSERT_SVH
`define BINNED_SCORE_HISTOGRAM_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BSH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsh assertion failed");
// next-cycle implication
`define BSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsh assertion failed");
`else
`define BSH_ASSERT_IMP(label, ante, cons)
`define BSH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/bsh_pkg.sv */
// ----------------------------------------------------------------------------
// bsh_pkg
// Bin edges, sizes, codes and shared types of the binned score histogram.
// ----------------------------------------------------------------------------
package bsh_pkg;

    localparam int CENT_BINS  = 8;
    localparam int PT_BINS    = 13;
    localparam int SCORE_BINS = 200;
    localparam int SCORE_ROW  = SCORE_BINS + 2;
    localparam int N_COUNTERS = CENT_BINS * PT_BINS * SCORE_ROW;

    localparam int ADDR_W  = $clog2(N_COUNTERS);
    localparam int ROW_W   = $clog2(CENT_BINS * PT_BINS + 3);
    localparam int CENT_W  = 3;
    localparam int PT_W    = 4;
    localparam int SBIN_W  = 8;
    localparam int COUNT_W = 32;
    localparam int LIM_W   = 15;
    localparam int MOM_W   = 16;
    localparam int VAL_W   = 16;

    localparam logic [LIM_W-1:0] RAP_LIMIT_RESET = LIM_W'(4096);

    // centrality: lower edge inclusive
    localparam logic [7:0] CENT_EDGE [0:CENT_BINS] =
        '{8'd0, 8'd10, 8'd20, 8'd40, 8'd60, 8'd80, 8'd100, 8'd160, 8'd200};
    // momentum in 10 MeV: upper edge inclusive
    localparam logic [MOM_W-1:0] PT_EDGE [0:PT_BINS] =
        '{16'd20, 16'd40, 16'd60, 16'd80, 16'd100, 16'd140, 16'd180,
          16'd220, 16'd280, 16'd360, 16'd460, 16'd600, 16'd700, 16'd850};

    // score in 1/1000 over [-1, 1)
    localparam int SCORE_LO    = -1000;
    localparam int SCORE_HI    = 1000;
    localparam int SCORE_SPAN  = SCORE_HI - SCORE_LO;
    localparam int SCORE_STEP  = SCORE_SPAN / SCORE_BINS;
    localparam int OFF_W       = $clog2(SCORE_SPAN);
    localparam int SCORE_SHIFT = 19;
    localparam int SCORE_RECIP = ((1 << SCORE_SHIFT) + SCORE_STEP - 1) / SCORE_STEP;
    localparam int RECIP_W     = $clog2(SCORE_RECIP + 1);

    typedef enum logic [1:0] {
        DROP_NONE = 2'd0,
        DROP_CENT = 2'd1,
        DROP_PT   = 2'd2,
        DROP_RAP  = 2'd3
    } t_drop;

    typedef enum logic {
        FUNC_FILL = 1'b0,
        FUNC_READ = 1'b1
    } t_func;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_bsh_state;

    // classified request handed from the binning logic to the pipeline
    typedef struct packed {
        logic              is_read;
        logic              in_range;  // read selection inside the bank
        logic              counted;   // fill that adds one
        logic              hit;       // needs a counter read
        t_drop             reason;
        logic [CENT_W-1:0] cent_bin;
        logic [PT_W-1:0]   pt_bin;
        logic [SBIN_W-1:0] score_bin;
    } t_bsh_cls;

endpackage

/* design/bsh_if.sv */
// ----------------------------------------------------------------------------
// bsh_if
// Request and response channels of the binned score histogram.
// ----------------------------------------------------------------------------
interface bsh_req_if
    import bsh_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [7:0]              centrality;
    logic [MOM_W-1:0]        momentum;
    logic signed [VAL_W-1:0] rapidity;
    logic signed [VAL_W-1:0] score;
    logic [CENT_W-1:0]       sel_cent_bin;
    logic [PT_W-1:0]         sel_pt_bin;
    logic [SBIN_W-1:0]       sel_score_bin;

    modport source (
        output valid, func, centrality, momentum, rapidity, score,
               sel_cent_bin, sel_pt_bin, sel_score_bin,
        input  ready
    );
    modport sink (
        input  valid, func, centrality, momentum, rapidity, score,
               sel_cent_bin, sel_pt_bin, sel_score_bin,
        output ready
    );
endinterface

interface bsh_rsp_if
    import bsh_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [1:0]         drop_reason;
    logic [CENT_W-1:0]  cent_bin;
    logic [PT_W-1:0]    pt_bin;
    logic [SBIN_W-1:0]  score_bin;
    logic [COUNT_W-1:0] count;

    modport source (
        output valid, accepted, drop_reason, cent_bin, pt_bin, score_bin, count,
        input  ready
    );
    modport sink (
        input  valid, accepted, drop_reason, cent_bin, pt_bin, score_bin, count,
        output ready
    );
endinterface

/* design/binned_score_histogram_top.sv */
// Path: a request passes stage 1, stage 2 and the output register to its response.
// Throughput: one request per cycle while the output register is free or drained;
//   the counter read-modify-write is a two-stage pipeline around the counter RAM, with a forward of the write.
// Reset: synchronous, active low. Afterwards a clearing pass zeroes all
//   21008 counters, one per cycle, before the first request is taken.
// ----------------------------------------------------------------------------
// binned_score_histogram_top
// Fill and read of saturating counters by centrality, momentum and score bin.
// ----------------------------------------------------------------------------
`include "binned_score_histogram_top_assert.svh"

module binned_score_histogram_top
    import bsh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    bsh_req_if.sink          i_req,
    bsh_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_wdata
);

    t_bsh_state         r_state;
    t_bsh_state         n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [ADDR_W-1:0]  n_clr_addr;
    logic               clr_we;
    logic               in_ready;
    logic               adv;
    logic               req_take;

    logic [LIM_W-1:0]   r_rap_limit;
    t_bsh_cls           cls;

    logic               r1_valid;
    t_bsh_cls           r1_cls;
    logic [ROW_W-1:0]   s1_row;
    logic [ADDR_W-1:0]  s1_addr;

    logic               r2_valid;
    t_bsh_cls           r2_cls;
    logic [ADDR_W-1:0]  r2_addr;
    logic               r2_fwd;
    logic [COUNT_W-1:0] r2_fwd_data;
    logic [COUNT_W-1:0] rd_data;
    logic [COUNT_W-1:0] s2_cur;
    logic [COUNT_W-1:0] s2_new;
    logic               s2_we;
    logic               fwd_hit;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;

    logic               r_out_valid;
    logic               r_out_accepted;
    t_drop              r_out_reason;
    logic [CENT_W-1:0]  r_out_cent;
    logic [PT_W-1:0]    r_out_pt;
    logic [SBIN_W-1:0]  r_out_score;
    logic [COUNT_W-1:0] r_out_count;

    // ---------------- control: clearing pass, then run
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(N_COUNTERS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        clr_we   = 1'b0;
        in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: clr_we   = 1'b1;
            ST_RUN:   in_ready = adv;
            default:  clr_we   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rap_limit <= RAP_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_rap_limit <= i_cfg_wdata;
        end
    end

    // whole pipeline moves when the output register is free or drained
    assign adv         = !r_out_valid || o_rsp.ready;
    assign i_req.ready = in_ready;
    assign req_take    = i_req.valid && in_ready;

    // ---------------- stage 1: classify and address
    bsh_classify u_classify (
        .i_func          (i_req.func),
        .i_centrality    (i_req.centrality),
        .i_momentum      (i_req.momentum),
        .i_rapidity      (i_req.rapidity),
        .i_score         (i_req.score),
        .i_sel_cent_bin  (i_req.sel_cent_bin),
        .i_sel_pt_bin    (i_req.sel_pt_bin),
        .i_sel_score_bin (i_req.sel_score_bin),
        .i_rap_limit     (r_rap_limit),
        .o_cls           (cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= req_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_cls <= cls;
        end
    end

    assign s1_row  = ROW_W'(r1_cls.cent_bin) * ROW_W'(PT_BINS) + ROW_W'(r1_cls.pt_bin);
    assign s1_addr = ADDR_W'(s1_row) * ADDR_W'(SCORE_ROW) + ADDR_W'(r1_cls.score_bin);

    // ---------------- stage 2: modify and write back
    assign s2_cur  = r2_fwd ? r2_fwd_data : rd_data;
    assign s2_new  = (s2_cur == '1) ? s2_cur : s2_cur + COUNT_W'(1);
    assign s2_we   = adv && r2_valid && r2_cls.counted;
    // stage-1 read misses a write landing in the same cycle
    assign fwd_hit = r2_valid && r2_cls.counted && r1_valid && r1_cls.hit
                   && (s1_addr == r2_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r2_fwd   <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
            r2_fwd   <= fwd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_cls      <= r1_cls;
            r2_addr     <= s1_addr;
            r2_fwd_data <= s2_new;
        end
    end

    assign ram_we    = clr_we || s2_we;
    assign ram_waddr = clr_we ? r_clr_addr : r2_addr;
    assign ram_wdata = clr_we ? '0 : s2_new;

    bsh_counter_ram u_counter_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (adv && r1_valid && r1_cls.hit),
        .i_rd_addr (s1_addr),
        .o_rd_data (rd_data)
    );

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_accepted <= r2_cls.counted;
            r_out_reason   <= r2_cls.reason;
            r_out_cent     <= r2_cls.cent_bin;
            r_out_pt       <= r2_cls.pt_bin;
            r_out_score    <= r2_cls.score_bin;
            if (r2_cls.counted) begin
                r_out_count <= s2_new;
            end else if (r2_cls.is_read && r2_cls.in_range) begin
                r_out_count <= s2_cur;
            end else begin
                r_out_count <= '0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.accepted    = r_out_accepted;
    assign o_rsp.drop_reason = r_out_reason;
    assign o_rsp.cent_bin    = r_out_cent;
    assign o_rsp.pt_bin      = r_out_pt;
    assign o_rsp.score_bin   = r_out_score;
    assign o_rsp.count       = r_out_count;

    // ---------------- assertions
    `BSH_ASSERT_IMP(a_clear_pipe_empty, r_state == ST_CLEAR, !r1_valid && !r2_valid && !r_out_valid)
    `BSH_ASSERT_IMP(a_fill_nonzero, o_rsp.valid && o_rsp.accepted, o_rsp.count != '0)
    `BSH_ASSERT_IMP(a_drop_no_count, o_rsp.valid && (o_rsp.drop_reason != DROP_NONE), !o_rsp.accepted && (o_rsp.count == '0))
    `BSH_ASSERT_NEXT(a_fwd_on_same_entry, adv && fwd_hit, r2_fwd && r2_cls.hit)

endmodule

/* design/bsh_classify.sv */
// ----------------------------------------------------------------------------
// bsh_classify
// Bin search and drop decision for one request, parallel comparators.
// ----------------------------------------------------------------------------
module bsh_classify
    import bsh_pkg::*;
(
    input  logic                    i_func,
    input  logic [7:0]              i_centrality,
    input  logic [MOM_W-1:0]        i_momentum,
    input  logic signed [VAL_W-1:0] i_rapidity,
    input  logic signed [VAL_W-1:0] i_score,
    input  logic [CENT_W-1:0]       i_sel_cent_bin,
    input  logic [PT_W-1:0]         i_sel_pt_bin,
    input  logic [SBIN_W-1:0]       i_sel_score_bin,
    input  logic [LIM_W-1:0]        i_rap_limit,
    output t_bsh_cls                o_cls
);

    localparam logic signed [VAL_W:0] SCORE_LO_S = (VAL_W + 1)'(SCORE_LO);
    localparam logic signed [VAL_W:0] SCORE_HI_S = (VAL_W + 1)'(SCORE_HI);
    localparam int PROD_W = OFF_W + RECIP_W;

    logic [CENT_W-1:0]       cent_bin;
    logic [PT_W-1:0]         pt_bin;
    logic signed [VAL_W:0]   score_ext;
    logic signed [VAL_W:0]   score_off;
    logic [PROD_W-1:0]       score_prod;
    logic [SBIN_W-1:0]       score_bin;
    logic signed [VAL_W:0]   rap_ext;
    logic signed [VAL_W:0]   lim_ext;
    logic                    rap_out;
    logic                    cent_out;
    logic                    pt_out;

    always_comb begin
        cent_bin = '0;
        for (int k = 1; k < CENT_BINS; k++) begin
            if (i_centrality >= CENT_EDGE[k]) begin
                cent_bin = CENT_W'(k);
            end
        end
        pt_bin = '0;
        for (int k = 1; k < PT_BINS; k++) begin
            if (i_momentum > PT_EDGE[k]) begin
                pt_bin = PT_W'(k);
            end
        end
    end

    // floor(offset / step) through a reciprocal multiply
    assign score_ext  = {i_score[VAL_W-1], i_score};
    assign score_off  = score_ext - SCORE_LO_S;
    assign score_prod = PROD_W'(score_off[OFF_W-1:0]) * PROD_W'(SCORE_RECIP);

    always_comb begin
        if (score_ext < SCORE_LO_S) begin
            score_bin = '0;
        end else if (score_ext >= SCORE_HI_S) begin
            score_bin = SBIN_W'(SCORE_BINS + 1);
        end else begin
            score_bin = score_prod[SCORE_SHIFT +: SBIN_W] + SBIN_W'(1);
        end
    end

    assign rap_ext  = {i_rapidity[VAL_W-1], i_rapidity};
    assign lim_ext  = {2'b00, i_rap_limit};
    assign rap_out  = (rap_ext > lim_ext) || (rap_ext < -lim_ext);
    assign cent_out = i_centrality >= CENT_EDGE[CENT_BINS];
    assign pt_out   = (i_momentum < PT_EDGE[0]) || (i_momentum > PT_EDGE[PT_BINS]);

    always_comb begin
        o_cls          = '0;
        o_cls.is_read  = (i_func == FUNC_READ);
        o_cls.in_range = (i_sel_cent_bin < CENT_BINS) && (i_sel_pt_bin < PT_BINS)
                       && (i_sel_score_bin < SCORE_ROW);
        if (i_func == FUNC_READ) begin
            o_cls.cent_bin  = i_sel_cent_bin;
            o_cls.pt_bin    = i_sel_pt_bin;
            o_cls.score_bin = i_sel_score_bin;
            o_cls.hit       = o_cls.in_range;
        end else begin
            o_cls.score_bin = score_bin;
            if (cent_out) begin
                o_cls.reason = DROP_CENT;
            end else if (pt_out) begin
                o_cls.reason   = DROP_PT;
                o_cls.cent_bin = cent_bin;
            end else if (rap_out) begin
                o_cls.reason   = DROP_RAP;
                o_cls.cent_bin = cent_bin;
                o_cls.pt_bin   = pt_bin;
            end else begin
                o_cls.cent_bin = cent_bin;
                o_cls.pt_bin   = pt_bin;
                o_cls.counted  = 1'b1;
                o_cls.hit      = 1'b1;
            end
        end
    end

endmodule

/* design/bsh_counter_ram.sv */
// ----------------------------------------------------------------------------
// bsh_counter_ram
// Counter bank: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsh_counter_ram
    import bsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic [COUNT_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic [COUNT_W-1:0] o_rd_data
);

    logic [COUNT_W-1:0] mem [0:N_COUNTERS-1];
    logic [COUNT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read returns the old word when the same entry is written in that cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* tb/tb_binned_score_histogram_top.sv */
// ----------------------------------------------------------------------------
// Binned score histogram testbench
// Drives fill and read requests into the histogram with random gaps on both
// channels and predicts every response: the bin search, the drop reason and
// the saturating counter bank. The rapidity limit is changed between phases.
// ----------------------------------------------------------------------------
module tb_binned_score_histogram_top;
    import bsh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT    = 100000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 170;
    localparam int HOT_KEYS       = 4;

    typedef struct packed {
        t_func                   func;
        logic [7:0]              centrality;
        logic [MOM_W-1:0]        momentum;
        logic signed [VAL_W-1:0] rapidity;
        logic signed [VAL_W-1:0] score;
        logic [CENT_W-1:0]       sel_cent;
        logic [PT_W-1:0]         sel_pt;
        logic [SBIN_W-1:0]       sel_score;
    } t_hist_req;

    localparam int REQ_W = $bits(t_hist_req);

    typedef struct packed {
        logic               accepted;
        t_drop              reason;
        logic [CENT_W-1:0]  cent_bin;
        logic [PT_W-1:0]    pt_bin;
        logic [SBIN_W-1:0]  score_bin;
        logic [COUNT_W-1:0] count;
    } t_hist_rsp;

    // histogram shadow: own counter bank plus the responses still owed
    class hist_scoreboard;
        bit [COUNT_W-1:0] counters [N_COUNTERS];
        int               rap_limit;
        t_hist_rsp        owed_rsp [$];
        int               n_errors;

        function new();
            rap_limit = int'(RAP_LIMIT_RESET);
            n_errors  = 0;
            foreach (counters[i]) counters[i] = '0;
        endfunction

        function int cent_bin_of(logic [7:0] cent);
            int b;
            b = 0;
            for (int k = 1; k < CENT_BINS; k++)
                if (cent >= CENT_EDGE[k]) b = k;
            return b;
        endfunction

        // upper edge inclusive
        function int pt_bin_of(logic [MOM_W-1:0] mom);
            int b;
            b = 0;
            for (int k = 1; k < PT_BINS; k++)
                if (mom > PT_EDGE[k]) b = k;
            return b;
        endfunction

        function int score_bin_of(logic signed [VAL_W-1:0] score);
            int s;
            s = $signed(score);
            if (s < SCORE_LO) return 0;
            if (s >= SCORE_HI) return SCORE_BINS + 1;
            return 1 + ((s - SCORE_LO) * SCORE_BINS) / SCORE_SPAN;
        endfunction

        function t_hist_rsp predict_fill_or_read(t_hist_req r);
            t_hist_rsp e;
            int        rap;
            int        idx;
            e = '0;
            e.reason = DROP_NONE;
            if (r.func == FUNC_READ) begin
                e.cent_bin  = r.sel_cent;
                e.pt_bin    = r.sel_pt;
                e.score_bin = r.sel_score;
                if (r.sel_cent < CENT_BINS && r.sel_pt < PT_BINS && r.sel_score < SCORE_ROW)
                    e.count = counters[(int'(r.sel_cent) * PT_BINS + int'(r.sel_pt)) * SCORE_ROW
                                       + int'(r.sel_score)];
            end else begin
                e.score_bin = SBIN_W'(score_bin_of(r.score));
                rap = $signed(r.rapidity);
                if (r.centrality >= CENT_EDGE[CENT_BINS]) begin
                    e.reason = DROP_CENT;
                end else begin
                    e.cent_bin = CENT_W'(cent_bin_of(r.centrality));
                    if (r.momentum < PT_EDGE[0] || r.momentum > PT_EDGE[PT_BINS]) begin
                        e.reason = DROP_PT;
                    end else begin
                        e.pt_bin = PT_W'(pt_bin_of(r.momentum));
                        if (rap < -rap_limit || rap > rap_limit) begin
                            e.reason = DROP_RAP;
                        end else begin
                            idx = (int'(e.cent_bin) * PT_BINS + int'(e.pt_bin)) * SCORE_ROW
                                  + int'(e.score_bin);
                            if (counters[idx] != '1) counters[idx]++;
                            e.count    = counters[idx];
                            e.accepted = 1'b1;
                        end
                    end
                end
            end
            return e;
        endfunction

        function void log_request(t_hist_req r);
            owed_rsp.push_back(predict_fill_or_read(r));
        endfunction

        function int pending();
            return owed_rsp.size();
        endfunction

        function void compare_field(string label, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                n_errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, label, want, got);
            end
        endfunction

        function void check_response(t_hist_rsp got);
            t_hist_rsp want;
            if (owed_rsp.size() == 0) begin
                n_errors++;
                $display("%0t: response with no request outstanding: expected none, actual %h",
                         $time, got);
                return;
            end
            want = owed_rsp.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("drop_reason", want.reason, got.reason);
            compare_field("cent_bin", want.cent_bin, got.cent_bin);
            compare_field("pt_bin", want.pt_bin, got.pt_bin);
            compare_field("score_bin", want.score_bin, got.score_bin);
            compare_field("count", want.count, got.count);
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [LIM_W-1:0] cfg_wdata;

    bsh_req_if req_ch ();
    bsh_rsp_if rsp_ch ();

    hist_scoreboard model;
    bit             steady_flow;
    int             quiet_cycles = 0;
    logic [7:0]              hot_cent  [HOT_KEYS];
    logic [MOM_W-1:0]        hot_mom   [HOT_KEYS];
    logic signed [VAL_W-1:0] hot_score [HOT_KEYS];

    binned_score_histogram_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_hist_req fill_req(int cent, int mom, int rap, int score);
        t_hist_req r;
        r = '0;
        r.func       = FUNC_FILL;
        r.centrality = 8'(cent);
        r.momentum   = MOM_W'(mom);
        r.rapidity   = VAL_W'(rap);
        r.score      = VAL_W'(score);
        return r;
    endfunction

    function automatic t_hist_req read_req(int cb, int pb, int sb);
        t_hist_req r;
        r = '0;
        r.func      = FUNC_READ;
        r.sel_cent  = CENT_W'(cb);
        r.sel_pt    = PT_W'(pb);
        r.sel_score = SBIN_W'(sb);
        return r;
    endfunction

    function automatic t_hist_req random_req();
        t_hist_req r;
        int        sel;
        int        k;
        int        lim;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, HOT_KEYS - 1);
        lim = model.rap_limit;
        r   = REQ_W'({$urandom, $urandom, $urandom});
        if (sel < 55) begin
            // mostly in-range fill, bin edges included; some on a repeated key
            r.func = FUNC_FILL;
            if (sel < 20) begin
                r.centrality = hot_cent[k];
                r.momentum   = hot_mom[k];
                r.score      = hot_score[k];
            end else begin
                if ($urandom_range(0, 4) == 0)
                    r.centrality = 8'(int'(CENT_EDGE[$urandom_range(0, CENT_BINS)])
                                      - int'($urandom_range(0, 1)));
                else
                    r.centrality = 8'($urandom_range(0, 199));
                if ($urandom_range(0, 4) == 0)
                    r.momentum = MOM_W'(int'(PT_EDGE[$urandom_range(0, PT_BINS)])
                                        + int'($urandom_range(0, 1)));
                else
                    r.momentum = MOM_W'($urandom_range(20, 850));
                if ($urandom_range(0, 6) != 0)
                    r.score = VAL_W'(int'($urandom_range(0, 1999)) - 1000);
            end
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: r.rapidity = VAL_W'(lim);
                    1: r.rapidity = VAL_W'(-lim);
                    2: r.rapidity = VAL_W'(lim + 1);
                    default: r.rapidity = VAL_W'(-lim - 1);
                endcase
            end else begin
                r.rapidity = VAL_W'(int'($urandom_range(0, 2 * lim)) - lim);
            end
        end else if (sel < 70) begin
            r.func = FUNC_FILL;
        end else if (sel < 85) begin
            r.func      = FUNC_READ;
            r.sel_cent  = CENT_W'(model.cent_bin_of(hot_cent[k]));
            r.sel_pt    = PT_W'(model.pt_bin_of(hot_mom[k]));
            r.sel_score = SBIN_W'(model.score_bin_of(hot_score[k]));
        end else begin
            r.func = FUNC_READ;
        end
        return r;
    endfunction

    task automatic send_request(input t_hist_req r);
        int gap;
        gap = steady_flow ? 0 : idle_length();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.func          <= r.func;
        req_ch.centrality    <= r.centrality;
        req_ch.momentum      <= r.momentum;
        req_ch.rapidity      <= r.rapidity;
        req_ch.score         <= r.score;
        req_ch.sel_cent_bin  <= r.sel_cent;
        req_ch.sel_pt_bin    <= r.sel_pt;
        req_ch.sel_score_bin <= r.sel_score;
        req_ch.valid         <= 1'b1;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        model.log_request(r);
    endtask

    task automatic wait_idle();
        while (model.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        model.rap_limit = value;
    endtask

    // response side: random back-pressure unless the phase runs steady
    initial begin
        int n;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = steady_flow ? 0 : idle_length();
            if (n > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_hist_rsp seen;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen.accepted  = rsp_ch.accepted;
            seen.reason    = t_drop'(rsp_ch.drop_reason);
            seen.cent_bin  = rsp_ch.cent_bin;
            seen.pt_bin    = rsp_ch.pt_bin;
            seen.score_bin = rsp_ch.score_bin;
            seen.count     = rsp_ch.count;
            model.check_response(seen);
        end
    end

    // covers the clearing pass after reset with plenty of margin
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_hist_req directed [$];
        int        phase_limit [PHASES];

        model        = new();
        steady_flow  = 1'b0;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.func          <= FUNC_FILL;
        req_ch.centrality    <= '0;
        req_ch.momentum      <= '0;
        req_ch.rapidity      <= '0;
        req_ch.score         <= '0;
        req_ch.sel_cent_bin  <= '0;
        req_ch.sel_pt_bin    <= '0;
        req_ch.sel_score_bin <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bin edges, score under/overflow, every drop and its priority,
        // read of fresh, filled and out-of-range counters; reset limit of 4096
        directed.push_back(read_req(0, 0, 0));
        directed.push_back(fill_req(0, 20, 0, -1000));
        directed.push_back(fill_req(0, 20, 0, -1000));
        directed.push_back(read_req(0, 0, 1));
        directed.push_back(fill_req(9, 40, 4096, -1001));
        directed.push_back(fill_req(10, 41, -4096, 999));
        directed.push_back(fill_req(199, 850, 0, 1000));
        directed.push_back(fill_req(200, 100, 0, 0));
        directed.push_back(fill_req(255, 19, 5000, 32767));
        directed.push_back(fill_req(160, 19, 0, -32768));
        directed.push_back(fill_req(100, 851, 0, 0));
        directed.push_back(fill_req(40, 100, 4097, 5));
        directed.push_back(fill_req(60, 101, -4097, -5));
        directed.push_back(fill_req(80, 65535, 0, 0));
        directed.push_back(fill_req(20, 700, -32768, 0));
        directed.push_back(fill_req(150, 300, 32767, 0));
        directed.push_back(fill_req(99, 600, 1, -1));
        directed.push_back(read_req(7, 12, 201));
        directed.push_back(read_req(7, 13, 0));
        directed.push_back(read_req(7, 15, 255));
        directed.push_back(read_req(3, 5, 202));
        directed.push_back(read_req(1, 1, 200));
        directed.push_back(fill_req(0, 0, 0, 0));
        directed.push_back(fill_req(60, 140, 0, 998));
        foreach (directed[i]) send_request(directed[i]);
        req_ch.valid <= 1'b0;
        wait_idle();

        phase_limit[0] = 0;
        phase_limit[1] = (1 << LIM_W) - 1;
        phase_limit[2] = 1;
        phase_limit[3] = $urandom_range(2, (1 << LIM_W) - 2);
        phase_limit[4] = int'(RAP_LIMIT_RESET);
        phase_limit[5] = $urandom_range(0, (1 << LIM_W) - 1);
        for (int p = 0; p < PHASES; p++) begin
            write_limit(LIM_W'(phase_limit[p]));
            steady_flow = (p == 2 || p == 4);
            for (int k = 0; k < HOT_KEYS; k++) begin
                hot_cent[k]  = 8'($urandom_range(0, 199));
                hot_mom[k]   = MOM_W'($urandom_range(20, 850));
                hot_score[k] = VAL_W'(int'($urandom_range(0, 2199)) - 1100);
            end
            repeat (PHASE_ITEMS) send_request(random_req());
            req_ch.valid <= 1'b0;
            wait_idle();
        end
        steady_flow = 1'b0;

        if (model.n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
